// ===== src/prb_pkg.sv =====
package prb_pkg;

  localparam int NTAPS = 5;

  localparam logic [1:0] REG_CENTER_COEF  = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [15:0] CENTER_COEF_RST  = 16'd26214;
  localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;

  typedef struct packed {
    logic [1:0]            nv;
    logic                  rend;
    logic [1:0]            fend;
    logic [1:0]            wslot;
    logic [1:0][4:0][1:0]  slot;
    logic [1:0][4:0]       cur;
  } prb_vctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_H_RUN,
    ST_H_FIN,
    ST_V_RUN,
    ST_V_FIN,
    ST_OUT,
    ST_WRITE
  } prb_state_t;

endpackage

// ===== src/prb_ram.sv =====
module prb_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/prb_fifo.sv =====
module prb_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int DEPTH = 4;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [1:0]       wptr;
  logic [1:0]       rptr;
  logic [2:0]       count;

  assign full  = (count == 3'(DEPTH));
  assign empty = (count == 3'd0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 2'd1;
      if (pop)  rptr <= rptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

// ===== src/prb_front.sv =====
module prb_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int PIXEL_BITS = 16,
  parameter int COLW       = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [PIXEL_BITS-1:0]            pixel_in,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [11:0]                      frame_width,
  input  logic [11:0]                      frame_height,
  input  logic                             restart,
  input  logic                             q_full,
  output logic                             q_push,
  output logic [4:0][PIXEL_BITS-1:0]       q_taps,
  output logic [COLW-1:0]                  q_col,
  output prb_pkg::prb_vctl_t               q_ctl
);
  import prb_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int PW = ((XW > YW) ? XW : YW) + 3;

  logic [3:0][PIXEL_BITS-1:0] win;
  logic [XW-1:0]              x;
  logic [YW-1:0]              r;
  logic                       pend_v;
  logic [4:0][PIXEL_BITS-1:0] pend_taps;
  logic [COLW-1:0]            pend_col;
  prb_vctl_t                  pend_ctl;

  logic signed [PW-1:0] w, h, xs, rs, last_c, last_vc;
  logic signed [PW-1:0] hc [2];
  logic signed [PW-1:0] vcs [2];
  logic                 hc0_v, hc1_v, vc0_v, vc1_v, accept;
  logic [4:0][PIXEL_BITS-1:0] jtaps [2];
  logic [COLW-1:0]            jcol [2];
  prb_vctl_t                  jctl [2];
  logic [1:0][4:0][1:0]       vslot;
  logic [1:0][4:0]            vcur;
  logic [1:0]                 vfe;
  logic [PIXEL_BITS-1:0]      win5 [5];

  function automatic logic signed [PW-1:0] mirror(input logic signed [PW-1:0] p,
                                                  input logic signed [PW-1:0] n);
    logic signed [PW-1:0] q;
    q = p;
    if (q < 0) q = -q;
    if (q > n - 1) q = PW'(2 * (n - 1) - q);
    if (q < 0) q = '0;
    if (q > n - 1) q = PW'(n - 1);
    return q;
  endfunction

  always_comb begin
    if (frame_width < 12'd5) w = PW'(5);
    else if (32'(frame_width) > MAX_WIDTH) w = PW'(MAX_WIDTH);
    else w = PW'(frame_width);
    if (frame_height < 12'd5) h = PW'(5);
    else if (32'(frame_height) > MAX_HEIGHT) h = PW'(MAX_HEIGHT);
    else h = PW'(frame_height);
  end

  assign xs      = $signed(PW'(x));
  assign rs      = $signed(PW'(r));
  assign last_c  = w[0] ? PW'(w - 1) : PW'(w - 2);
  assign last_vc = h[0] ? PW'(h - 1) : PW'(h - 2);

  assign hc0_v = !x[0] && (xs >= 2);
  assign hc1_v = (xs == w - 1);
  assign hc[0] = PW'(xs - 2);
  assign hc[1] = x[0] ? PW'(xs - 1) : xs;

  assign vc0_v  = !r[0] && (rs >= 2);
  assign vc1_v  = (rs == h - 1);
  assign vcs[0] = vc0_v ? PW'(rs - 2) : (r[0] ? PW'(rs - 1) : rs);
  assign vcs[1] = r[0] ? PW'(rs - 1) : rs;

  always_comb begin
    logic signed [PW-1:0] p;
    for (int b = 0; b < 2; b++) begin
      for (int k = 0; k < NTAPS; k++) begin
        p = mirror(PW'(vcs[b] - 2 + k), h);
        vslot[b][k] = p[1:0];
        vcur[b][k]  = (p == rs);
      end
      vfe[b] = (vcs[b] == last_vc);
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) win5[k] = win[k];
    win5[4] = pixel_in;
  end

  always_comb begin
    logic signed [PW-1:0] p, d;
    logic [2:0]           idx;
    for (int j = 0; j < 2; j++) begin
      for (int k = 0; k < NTAPS; k++) begin
        p = mirror(PW'(hc[j] - 2 + k), w);
        d = PW'(p - (xs - 4));
        if (d < 0) idx = 3'd0;
        else if (d > 4) idx = 3'd4;
        else idx = d[2:0];
        jtaps[j][k] = win5[idx];
      end
      jcol[j]        = hc[j][COLW:1];
      jctl[j].nv     = 2'(vc0_v) + 2'(vc1_v);
      jctl[j].rend   = (hc[j] == last_c);
      jctl[j].fend   = {2{jctl[j].rend}} & vfe;
      jctl[j].wslot  = r[1:0];
      jctl[j].slot   = vslot;
      jctl[j].cur    = vcur;
    end
  end

  assign in_stall = pend_v || q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = pend_v ? !q_full : (accept && (hc0_v || hc1_v));
  assign q_taps   = pend_v ? pend_taps : (hc0_v ? jtaps[0] : jtaps[1]);
  assign q_col    = pend_v ? pend_col : (hc0_v ? jcol[0] : jcol[1]);
  assign q_ctl    = pend_v ? pend_ctl : (hc0_v ? jctl[0] : jctl[1]);

  always_ff @(posedge clk) begin
    if (accept) begin
      win <= {pixel_in, win[3:1]};
      pend_taps <= jtaps[1];
      pend_col  <= jcol[1];
      pend_ctl  <= jctl[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x      <= '0;
      r      <= '0;
      pend_v <= 1'b0;
    end else begin
      if (accept && hc0_v && hc1_v) pend_v <= 1'b1;
      else if (pend_v && !q_full)   pend_v <= 1'b0;
      if (restart) begin
        x <= '0;
        r <= '0;
      end else if (accept) begin
        if (xs >= w - 1) begin
          x <= '0;
          r <= (rs >= h - 1) ? '0 : r + 1'b1;
        end else begin
          x <= x + 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/prb_back.sv =====
module prb_back #(
  parameter int PIXEL_BITS = 16,
  parameter int COLW       = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [15:0]                center_coef,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  logic [4:0][PIXEL_BITS-1:0] q_taps,
  input  logic [COLW-1:0]            q_col,
  input  prb_pkg::prb_vctl_t         q_ctl,
  output logic [PIXEL_BITS-1:0]      pixel_out,
  output logic                       row_end,
  output logic                       frame_end,
  output logic                       out_valid,
  input  logic                       out_stall
);
  import prb_pkg::*;

  localparam int HW  = PIXEL_BITS + 9;
  localparam int PRW = HW + 18;
  localparam int AW  = PIXEL_BITS + 30;
  localparam int MA  = COLW + 2;
  localparam logic signed [AW-1:0] HMAX = {{(AW-HW+1){1'b0}}, {(HW-1){1'b1}}};
  localparam logic signed [AW-1:0] HMIN = ~HMAX;
  localparam logic signed [AW-1:0] PMAX = {{(AW-PIXEL_BITS){1'b0}}, {PIXEL_BITS{1'b1}}};
  localparam logic signed [AW-1:0] HRND = {{(AW-9){1'b0}}, 1'b1, 8'd0};
  localparam logic signed [AW-1:0] VRND = {{(AW-25){1'b0}}, 1'b1, 24'd0};

  prb_state_t state, state_next;

  logic [4:0][PIXEL_BITS-1:0] taps;
  logic [COLW-1:0]            col;
  prb_vctl_t                  ctl;
  logic                       b;
  logic [2:0]                 kiss, kidx;
  logic                       issue, run, fire;
  logic                       s1_v, s1_h, s1_cur, s2_v;
  logic [2:0]                 s1_k, s2_k;
  logic signed [PRW-1:0]      prod;
  logic signed [AW-1:0]       acc, ht, vt, hs, vs;
  logic signed [HW-1:0]       hval, operand;
  logic signed [17:0]         a18, coef;
  logic [PIXEL_BITS-1:0]      pix;
  logic [HW-1:0]              rdata;

  assign run   = (state == ST_H_RUN) || (state == ST_V_RUN);
  assign issue = run && (kiss < 3'd5);
  assign kidx  = (kiss < 3'd5) ? kiss : 3'd0;
  assign fire  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = ST_H_RUN;
        end
      end
      ST_H_RUN: if (s2_v && s2_k == 3'd4) state_next = ST_H_FIN;
      ST_H_FIN: state_next = (ctl.nv != 2'd0) ? ST_V_RUN : ST_WRITE;
      ST_V_RUN: if (s2_v && s2_k == 3'd4) state_next = ST_V_FIN;
      ST_V_FIN: state_next = ST_OUT;
      ST_OUT: begin
        if (fire) state_next = (!b && ctl.nv == 2'd2) ? ST_V_RUN : ST_WRITE;
      end
      ST_WRITE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  prb_ram #(.WIDTH(HW), .DEPTH(1 << MA)) u_lines (
    .clk   (clk),
    .we    (state == ST_WRITE),
    .waddr ({ctl.wslot, col}),
    .wdata (hval),
    .raddr ({ctl.slot[b][kidx], col}),
    .rdata (rdata)
  );

  assign a18 = $signed(18'(center_coef));

  always_comb begin
    if (s1_k == 3'd2)                      coef = a18 <<< 1;
    else if (s1_k == 3'd1 || s1_k == 3'd3) coef = 18'sd32768;
    else                                   coef = 18'sd32768 - a18;
    if (s1_h)        operand = $signed(HW'(taps[s1_k]));
    else if (s1_cur) operand = hval;
    else             operand = $signed(rdata);
  end

  always_comb begin
    ht = acc + HRND;
    hs = ht >>> 9;
    vt = acc + VRND;
    vs = vt >>> 25;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      taps <= q_taps;
      col  <= q_col;
      ctl  <= q_ctl;
    end
    s1_k   <= kidx;
    s1_h   <= (state == ST_H_RUN);
    s1_cur <= ctl.cur[b][kidx];
    s2_k   <= s1_k;
    prod   <= operand * coef;
    acc    <= run ? (s2_v ? acc + AW'(prod) : acc) : '0;
    if (state == ST_H_FIN) begin
      if (hs > HMAX)      hval <= HW'(HMAX);
      else if (hs < HMIN) hval <= HW'(HMIN);
      else                hval <= HW'(hs);
    end
    if (state == ST_V_FIN) begin
      if (vs > PMAX)   pix <= PIXEL_BITS'(PMAX);
      else if (vs < 0) pix <= '0;
      else             pix <= PIXEL_BITS'(vs);
    end
    if (state == ST_OUT && fire) begin
      pixel_out <= pix;
      row_end   <= ctl.rend;
      frame_end <= ctl.fend[b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kiss      <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      b         <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      kiss <= run ? (issue ? kiss + 3'd1 : kiss) : 3'd0;
      s1_v <= issue;
      s2_v <= s1_v;
      if (q_pop) b <= 1'b0;
      else if (state == ST_OUT && fire) b <= 1'b1;
      if (state == ST_OUT && fire)   out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("job taken from an empty queue");

  a_fin_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_H_FIN || state == ST_V_FIN) |-> (kiss == 3'd5 && !s1_v && !s2_v))
    else $error("accumulator finished with taps still in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_valid && out_stall) |=> (state == ST_OUT))
    else $error("result left before the output register was free");

endmodule

// ===== src/pyramid_reduce_by_two_top.sv =====
// One horizontal job per even column; a job with no output rows makes the horizontal pass
// only, and one that yields one or two output words adds one or two vertical passes (one tap per cycle
// through the shared multiply-accumulate unit and the single line-store read port).
// The back part takes the next job from the queue only once it is idle again; jobs waiting
// in the queue and output stalls delay a job's output words.
// Synchronous reset clears counters, queue and control; the line store is not cleared.
module pyramid_reduce_by_two_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int PIXEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [PIXEL_BITS-1:0] pixel_in,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic [PIXEL_BITS-1:0] pixel_out,
  output logic                  row_end,
  output logic                  frame_end,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data
);
  import prb_pkg::*;

  localparam int LINE_LEN = (MAX_WIDTH + 1) / 2;
  localparam int COLW     = $clog2(LINE_LEN);
  localparam int QW       = 5 * PIXEL_BITS + COLW + $bits(prb_vctl_t);

  logic [15:0] center_coef;
  logic [11:0] frame_width;
  logic [11:0] frame_height;
  logic        restart;

  logic                       q_push, q_pop, q_full, q_empty;
  logic [4:0][PIXEL_BITS-1:0] f_taps, b_taps;
  logic [COLW-1:0]            f_col, b_col;
  prb_vctl_t                  f_ctl, b_ctl;
  logic [QW-1:0]              q_out;

  assign restart = cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_coef  <= CENTER_COEF_RST;
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_COEF:  center_coef  <= cfg_data;
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[11:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  prb_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .PIXEL_BITS(PIXEL_BITS),
    .COLW      (COLW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .pixel_in     (pixel_in),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .restart      (restart),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_taps       (f_taps),
    .q_col        (f_col),
    .q_ctl        (f_ctl)
  );

  prb_fifo #(.WIDTH(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   ({f_taps, f_col, f_ctl}),
    .pop   (q_pop),
    .dout  (q_out),
    .full  (q_full),
    .empty (q_empty)
  );

  assign {b_taps, b_col, b_ctl} = q_out;

  prb_back #(
    .PIXEL_BITS(PIXEL_BITS),
    .COLW      (COLW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .center_coef (center_coef),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_taps      (b_taps),
    .q_col       (b_col),
    .q_ctl       (b_ctl),
    .pixel_out   (pixel_out),
    .row_end     (row_end),
    .frame_end   (frame_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
  );

endmodule
